>>> rtl/core/mm2a_pkg.sv
// ----------------------------------------------------------------------------
// MurmurHash2A package
// Widths, mixing constants and the microcode program of the hash sequencer.
// ----------------------------------------------------------------------------
package mm2a_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned StepW  = 4;

  localparam logic [WordW-1:0] MixMul = 32'h5bd1_e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;

  localparam logic [CountW-1:0] FullCount = 3'd4;

  typedef enum logic [2:0] {
    OP_WORD = 3'd0,
    OP_TAIL = 3'd1,
    OP_LEN  = 3'd2,
    OP_KX   = 3'd3,
    OP_H    = 3'd4,
    OP_HFIN = 3'd5
  } operand_t;

  typedef enum logic [1:0] {
    DST_K   = 2'd0,
    DST_H   = 2'd1,
    DST_HXK = 2'd2
  } dest_t;

  typedef enum logic [1:0] {
    FLOW_NEXT     = 2'd0,
    FLOW_WORD_END = 2'd1,
    FLOW_EMIT     = 2'd2,
    FLOW_STOP     = 2'd3
  } flow_t;

  typedef struct packed {
    operand_t op;
    dest_t    dst;
    flow_t    flow;
  } ucode_t;

  localparam logic [StepW-1:0] StepWord = 4'd0;
  localparam logic [StepW-1:0] StepTail = 4'd3;
  localparam logic [StepW-1:0] StepEmit = 4'd9;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] addr);
    ucode_t uc;
    unique case (addr)
      4'd0:    uc = '{OP_WORD, DST_K,   FLOW_NEXT};
      4'd1:    uc = '{OP_KX,   DST_K,   FLOW_NEXT};
      4'd2:    uc = '{OP_H,    DST_HXK, FLOW_WORD_END};
      4'd3:    uc = '{OP_TAIL, DST_K,   FLOW_NEXT};
      4'd4:    uc = '{OP_KX,   DST_K,   FLOW_NEXT};
      4'd5:    uc = '{OP_H,    DST_HXK, FLOW_NEXT};
      4'd6:    uc = '{OP_LEN,  DST_K,   FLOW_NEXT};
      4'd7:    uc = '{OP_KX,   DST_K,   FLOW_NEXT};
      4'd8:    uc = '{OP_H,    DST_HXK, FLOW_NEXT};
      4'd9:    uc = '{OP_HFIN, DST_H,   FLOW_EMIT};
      default: uc = '{OP_H,    DST_K,   FLOW_STOP};
    endcase
    return uc;
  endfunction

  function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] count);
    logic [WordW-1:0] mask;
    unique case (count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'h0000_0000;
    endcase
    return mask;
  endfunction

endpackage

>>> rtl/core/mm2a_word_if.sv
// ----------------------------------------------------------------------------
// MurmurHash2A key word channel
// Valid/ready channel carrying one little-endian key word and its markers.
// ----------------------------------------------------------------------------
interface mm2a_word_if;
  logic                         valid;
  logic                         ready;
  logic [mm2a_pkg::WordW-1:0]   data_word;
  logic [mm2a_pkg::CountW-1:0]  byte_count;
  logic                         last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

>>> rtl/core/mm2a_hash_if.sv
// ----------------------------------------------------------------------------
// MurmurHash2A result channel
// Valid/ready channel carrying one finished 32-bit hash.
// ----------------------------------------------------------------------------
interface mm2a_hash_if;
  logic                       valid;
  logic                       ready;
  logic [mm2a_pkg::WordW-1:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

>>> rtl/core/mm2a_seed_if.sv
// ----------------------------------------------------------------------------
// MurmurHash2A seed write channel
// Valid/ready channel carrying the write data of the seed register.
// ----------------------------------------------------------------------------
interface mm2a_seed_if;
  logic                       valid;
  logic                       ready;
  logic [mm2a_pkg::WordW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/murmur2a_hash_stream_unit.sv
// ----------------------------------------------------------------------------
// MurmurHash2A stream unit
// Hashes keys streamed as 32-bit words with a microcoded multiply datapath.
// ----------------------------------------------------------------------------
// A word that is not last takes three passes through the one 32x32 multiplier;
// the next key word can be taken in the same cycle as its last pass.
// A last word runs microcode steps 0 to 9 when full and 3 to 9 when short,
// the last loading the result register; the next key word is taken after that.
// Reset clears the seed to zero, empties the result register and arms the
// key start; no clearing pass is needed.
// ----------------------------------------------------------------------------
module murmur2a_hash_stream_unit (
  input  logic         clk,
  input  logic         rst,
  mm2a_word_if.sink    key_words,
  mm2a_hash_if.source  hashes,
  mm2a_seed_if.sink    seed_cfg
);
  import mm2a_pkg::*;

  logic [WordW-1:0]  seed;
  logic [WordW-1:0]  h;
  logic [WordW-1:0]  k;
  logic [WordW-1:0]  len;
  logic [WordW-1:0]  len_next;
  logic [WordW-1:0]  word;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic              last;
  logic              at_start;
  logic              busy;
  logic [StepW-1:0]  step;
  logic [WordW-1:0]  out_hash;
  logic              out_valid;

  ucode_t            uc;
  logic [WordW-1:0]  operand;
  logic [WordW-1:0]  product;
  logic              adv;
  logic              word_done;
  logic              emit_load;
  logic              take;

  assign seed_cfg.ready = 1'b1;
  assign hashes.valid   = out_valid;
  assign hashes.hash    = out_hash;

  assign uc = ucode_rom(step);

  always_comb begin
    unique case (uc.op)
      OP_WORD: operand = word;
      OP_TAIL: operand = word & tail_mask(count);
      OP_LEN:  operand = len;
      OP_KX:   operand = k ^ (k >> MixShift);
      OP_H:    operand = h;
      OP_HFIN: operand = h ^ (h >> FinShiftA);
      default: operand = h;
    endcase
  end

  assign product = operand * MixMul;

  assign adv       = busy && !(uc.flow == FLOW_EMIT && out_valid && !hashes.ready);
  assign word_done = adv && uc.flow == FLOW_WORD_END && !last;
  assign emit_load = adv && uc.flow == FLOW_EMIT;

  assign key_words.ready = !busy || word_done;
  assign take            = key_words.valid && key_words.ready;

  always_comb begin
    if (!key_words.last) begin
      count_next = FullCount;
    end else if (key_words.byte_count > FullCount) begin
      count_next = FullCount;
    end else begin
      count_next = key_words.byte_count;
    end
    len_next = (at_start ? '0 : len) + {{(WordW-CountW){1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      busy      <= 1'b0;
      step      <= StepWord;
      at_start  <= 1'b1;
      out_valid <= 1'b0;
      len       <= '0;
    end else begin
      if (seed_cfg.valid && seed_cfg.ready) begin
        seed <= seed_cfg.data;
      end

      if (adv) begin
        unique case (uc.dst)
          DST_K:   k <= product;
          DST_H:   h <= product;
          DST_HXK: h <= product ^ k;
          default: k <= product;
        endcase
      end

      if (emit_load) begin
        out_valid <= 1'b1;
        out_hash  <= product ^ (product >> FinShiftB);
      end else if (hashes.ready) begin
        out_valid <= 1'b0;
      end

      if (take) begin
        word     <= key_words.data_word;
        count    <= count_next;
        last     <= key_words.last;
        len      <= len_next;
        at_start <= key_words.last;
        busy     <= 1'b1;
        step     <= (key_words.last && count_next != FullCount) ? StepTail : StepWord;
        if (at_start) begin
          h <= seed;
        end
      end else if (adv) begin
        unique case (uc.flow)
          FLOW_NEXT:     step <= step + 1'b1;
          FLOW_WORD_END: begin
            if (last) begin
              step <= step + 1'b1;
            end else begin
              busy <= 1'b0;
            end
          end
          FLOW_EMIT:     busy <= 1'b0;
          FLOW_STOP:     busy <= 1'b0;
          default:       busy <= 1'b0;
        endcase
      end
    end
  end

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("Sequencer did not start after a word transfer.");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= StepEmit)
    else $error("Step counter left the microcode program.");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> at_start && !busy)
    else $error("Key start not armed after a result was loaded.");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (hashes.valid && hashes.ready && !emit_load) |=> !hashes.valid)
    else $error("Result register held a hash after its transfer.");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2A stream unit testbench
// Streams keys into the hash unit word by word. Each finished hash is checked
// against an in-bench model of the hash, or against the row's own hash for a
// pinned table row. A short table of directed keys covers the edge cases, and
// three phases of random keys follow with varying handshake idling, seed values
// and one long stall of the result channel.
module tb_top;
  import mm2a_pkg::*;

  localparam int unsigned RandomItems  = 950;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PlanLen      = 21;

  typedef struct packed {
    logic              seed_wr;
    logic [WordW-1:0]  seed_val;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              last;
    logic              pinned;
    logic [WordW-1:0]  hash;
  } plan_row_t;

  localparam plan_row_t Plan [0:PlanLen-1] = '{
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd1, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd2, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd3, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 3'd5, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 3'd6, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 3'd7, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 3'd4, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hffff_ffff, 3'd7, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'ha5a5_a5a5, 3'd3, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h5a5a_5a5a, 3'd2, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0001, 3'd5, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b1, 32'hffff_ffff, 32'hffff_0000, 3'd0, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h8000_0000, 3'd4, 1'b0, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h7fff_ffff, 3'd4, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h00ff_ffff, 3'd3, 1'b1, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_00ff, 3'd1, 1'b1, 1'b0, 32'h0000_0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mm2a_word_if key_words ();
  mm2a_hash_if hashes ();
  mm2a_seed_if seed_cfg ();

  murmur2a_hash_stream_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .key_words (key_words),
    .hashes    (hashes),
    .seed_cfg  (seed_cfg)
  );

  always #5ns clk = ~clk;

  logic [WordW-1:0] seed_q    = '0;
  logic [WordW-1:0] key_hash  = '0;
  logic [WordW-1:0] key_bytes = '0;
  logic             key_open  = 1'b0;
  logic [WordW-1:0] hash_queue [$];
  logic [WordW-1:0] hash_want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned words_sent    = 0;
  int unsigned keys_sent     = 0;
  int unsigned hashes_seen   = 0;
  int unsigned seed_writes   = 0;
  int unsigned longest_key   = 0;

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] h,
                                                input logic [WordW-1:0] k);
    logic [WordW-1:0] m;
    m = k * MixMul;
    m = m ^ (m >> MixShift);
    m = m * MixMul;
    return (h * MixMul) ^ m;
  endfunction

  function automatic logic hash_word(input logic [WordW-1:0] word,
                                     input logic [CountW-1:0] count,
                                     input logic is_last,
                                     output logic [WordW-1:0] hash);
    logic [WordW-1:0]  h;
    logic [WordW-1:0]  tail;
    logic [CountW-1:0] n;
    hash = '0;
    if (!key_open) begin
      key_hash  = seed_q;
      key_bytes = '0;
      key_open  = 1'b1;
    end
    if (!is_last) begin
      key_hash  = mix_word(key_hash, word);
      key_bytes = key_bytes + 32'd4;
      return 1'b0;
    end
    n    = (count > FullCount) ? FullCount : count;
    h    = key_hash;
    tail = '0;
    if (n == FullCount) begin
      h = mix_word(h, word);
    end else begin
      tail = word & ((32'h1 << (8 * n)) - 32'h1);
    end
    key_bytes = key_bytes + WordW'(n);
    h = mix_word(h, tail);
    h = mix_word(h, key_bytes);
    h = h ^ (h >> FinShiftA);
    h = h * MixMul;
    h = h ^ (h >> FinShiftB);
    key_open = 1'b0;
    hash     = h;
    return 1'b1;
  endfunction

  task automatic put_word(input logic [WordW-1:0] word, input logic [CountW-1:0] count,
                          input logic is_last, input logic pinned,
                          input logic [WordW-1:0] pin_hash);
    logic [WordW-1:0] hash;
    while ($urandom_range(99) < send_idle_pct) begin
      key_words.valid <= 1'b0;
      @(negedge clk);
    end
    key_words.valid      <= 1'b1;
    key_words.data_word  <= word;
    key_words.byte_count <= count;
    key_words.last       <= is_last;
    do @(posedge clk); while (!(key_words.valid && key_words.ready));
    if (hash_word(word, count, is_last, hash)) begin
      hash_queue.insert(hash_queue.size(), pinned ? pin_hash : hash);
      keys_sent++;
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    key_words.valid <= 1'b0;
    while (hash_queue.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_seed(input logic [WordW-1:0] value);
    drain();
    seed_cfg.valid <= 1'b1;
    seed_cfg.data  <= value;
    do @(posedge clk); while (!(seed_cfg.valid && seed_cfg.ready));
    seed_q = value;
    seed_writes++;
    @(negedge clk);
    seed_cfg.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && hashes.valid && hashes.ready) begin
      if (hash_queue.size() == 0) begin
        $error("hash: result %08h arrived with none expected", hashes.hash);
        fail_count++;
      end else begin
        hash_want = hash_queue.pop_front();
        hashes_seen++;
        if (hashes.hash !== hash_want) begin
          $error("hash mismatch: expected %08h, actual %08h", hash_want, hashes.hash);
          fail_count++;
        end
      end
    end
  end

  initial begin
    hashes.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hashes.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      hashes.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #5ms;
    $error("timeout: run did not complete");
    $display("[murmur2a_hash_stream_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned      target;
    int unsigned      key_len;
    logic [WordW-1:0] w;
    logic [CountW-1:0] c;
    key_words.valid      = 1'b0;
    key_words.data_word  = '0;
    key_words.byte_count = '0;
    key_words.last       = 1'b0;
    seed_cfg.valid       = 1'b0;
    seed_cfg.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 73;
    foreach (Plan[i]) begin
      if (Plan[i].seed_wr) write_seed(Plan[i].seed_val);
      put_word(Plan[i].word, Plan[i].count, Plan[i].last, Plan[i].pinned, Plan[i].hash);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: write_seed(32'h8000_0001);
        1: write_seed($urandom);
        default: write_seed(32'h0000_0000);
      endcase
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
      // With both sides busy, a long result stall lets the unit back up into its input.
      if (phase == 2) hold_off_req = 1'b1;
      target = words_sent + RandomItems / 3;
      while (words_sent < target) begin
        key_len = ($urandom_range(3) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
        if (key_len > longest_key) longest_key = key_len;
        for (int j = 1; j <= key_len; j++) begin
          case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            default: w = $urandom;
          endcase
          if (j < key_len) begin
            c = CountW'($urandom_range(7));
          end else begin
            c = ($urandom_range(9) < 8) ? CountW'($urandom_range(4, 0))
                                        : CountW'($urandom_range(7, 5));
          end
          put_word(w, c, j == key_len, 1'b0, '0);
        end
      end
    end

    drain();
    $display("Run covered %0d key words in %0d keys, longest random key %0d words,",
             words_sent, keys_sent, longest_key);
    $display("%0d hashes checked; seed written %0d times under three idling patterns %s",
             hashes_seen, seed_writes, "and one long result stall.");
    if (fail_count == 0) begin
      $display("[murmur2a_hash_stream_unit] OK");
    end else begin
      $display("[murmur2a_hash_stream_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mm2a_pkg.sv
rtl/core/mm2a_word_if.sv
rtl/core/mm2a_hash_if.sv
rtl/core/mm2a_seed_if.sv
rtl/core/murmur2a_hash_stream_unit.sv
test/tb_top.sv
